>>> design/lpc_rs_pkg.sv
// Shared types, constants and microcode program for the LPC sample restoration block.
package lpc_rs_pkg;

  localparam int MAX_ORDER_DEF = 32;
  localparam int ORDER_W       = 6;
  localparam int PREC_W        = 4;
  localparam int SHIFT_W       = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 6;
  localparam int SAMPLE_W      = 32;
  localparam int COEF_W        = 15;
  localparam int PROD_W        = COEF_W + SAMPLE_W;
  localparam int ACC_W         = 64;

  localparam logic [ORDER_W-1:0] ORDER_RST = 6'd1;
  localparam logic [PREC_W-1:0]  PREC_RST  = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd0;

  localparam logic [CFG_IDX_W-1:0] REG_LPC_ORDER        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PRECISION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTION_SHIFT = 2'd2;

  typedef enum logic [1:0] {
    OP_COEF = 2'd0,
    OP_WARM = 2'd1,
    OP_RES  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_OUT_BUSY,
    C_SHORT,
    C_TAP_MORE
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_COEF   = 4'd1;
  localparam step_t ST_WARM_W = 4'd2;
  localparam step_t ST_WARM   = 4'd3;
  localparam step_t ST_RCHK   = 4'd4;
  localparam step_t ST_MAC    = 4'd5;
  localparam step_t ST_DR1    = 4'd6;
  localparam step_t ST_DR2    = 4'd7;
  localparam step_t ST_RES_W  = 4'd8;
  localparam step_t ST_RES    = 4'd9;
  localparam step_t ST_ERR_W  = 4'd10;
  localparam step_t ST_ERR    = 4'd11;
  localparam step_t ST_NOP    = 4'd12;
  localparam step_t ST_LAST   = ST_NOP;

  typedef struct packed {
    logic in_rdy;
    logic coef_wr;
    logic warm;
    logic mac_clr;
    logic tap_rd;
    logic res;
    logic err;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
    logic short_cnt;
    logic tap_more;
  } sts_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_t cond;
    step_t target;
  } rom_word_t;

  localparam ctl_t CTL_NONE = '0;

  function automatic step_t dispatch(input op_t op);
    step_t s;
    s = ST_NOP;
    unique case (op)
      OP_COEF: s = ST_COEF;
      OP_WARM: s = ST_WARM_W;
      OP_RES:  s = ST_RCHK;
      OP_NONE: s = ST_NOP;
      default: s = ST_NOP;
    endcase
    return s;
  endfunction

  function automatic rom_word_t microcode(input step_t s);
    rom_word_t w;
    w = '{ctl: CTL_NONE, cond: C_ALWAYS, target: ST_IDLE};
    unique case (s)
      ST_IDLE: begin
        w.ctl.in_rdy = 1'b1;
        w.cond = C_DISPATCH;
      end
      ST_COEF:   w.ctl.coef_wr = 1'b1;
      ST_WARM_W: begin
        w.cond = C_OUT_BUSY;
        w.target = ST_WARM_W;
      end
      ST_WARM:   w.ctl.warm = 1'b1;
      ST_RCHK: begin
        w.ctl.mac_clr = 1'b1;
        w.cond = C_SHORT;
        w.target = ST_ERR_W;
      end
      ST_MAC: begin
        w.ctl.tap_rd = 1'b1;
        w.cond = C_TAP_MORE;
        w.target = ST_MAC;
      end
      ST_DR1:    w.target = ST_DR2;
      ST_DR2:    w.target = ST_RES_W;
      ST_RES_W: begin
        w.cond = C_OUT_BUSY;
        w.target = ST_RES_W;
      end
      ST_RES:    w.ctl.res = 1'b1;
      ST_ERR_W: begin
        w.cond = C_OUT_BUSY;
        w.target = ST_ERR_W;
      end
      ST_ERR:    w.ctl.err = 1'b1;
      default:   w.target = ST_IDLE;
    endcase
    return w;
  endfunction

endpackage

>>> design/lpc_rs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpc_rs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lpc_rs_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module lpc_rs_seq
  import lpc_rs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  input  sts_t sts,
  output ctl_t ctl
);

  step_t     step;
  step_t     step_next;
  rom_word_t word;
  logic      accept;

  assign word   = microcode(step);
  assign ctl    = word.ctl;
  assign accept = in_valid && word.ctl.in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next = step + step_t'(1);
    unique case (word.cond)
      C_ALWAYS:   step_next = word.target;
      C_DISPATCH: step_next = accept ? dispatch(in_op) : step;
      C_OUT_BUSY: if (sts.out_busy) step_next = word.target;
      C_SHORT:    if (sts.short_cnt) step_next = word.target;
      C_TAP_MORE: if (sts.tap_more) step_next = word.target;
      default:    step_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= ST_LAST)
    else $error("step counter outside program");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst) accept |=> step != ST_IDLE)
    else $error("accepted transfer not dispatched");
`endif

endmodule

>>> design/lpc_rs_dp.sv
// Datapath: registers, coefficient and history RAMs, MAC pipeline, result register.
module lpc_rs_dp
  import lpc_rs_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_accept,
  input  logic [SAMPLE_W-1:0]   in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic                  out_last,
  output logic                  out_error
);

  localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int HDEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_ORDER + 1);

  logic [ORDER_W-1:0] lpc_order;
  logic [PREC_W-1:0]  coef_precision;
  logic [SHIFT_W-1:0] prediction_shift;

  logic [SAMPLE_W-1:0] val_q;
  logic                last_q;

  logic [CW-1:0] coef_count;
  logic [CW-1:0] warm_count;
  logic [CW-1:0] tap;
  logic [AW-1:0] wp;
  logic [CW-1:0] eff_order;
  logic [ORDER_W-1:0] clamp;

  logic [PREC_W-1:0]  prec;
  logic [COEF_W-1:0]  coef_ext;
  logic [COEF_W-1:0]  coef_rdata;
  logic [SAMPLE_W-1:0] hist_rdata;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic [AW-1:0]      hist_raddr;
  logic               hist_we;
  logic               coef_we;

  logic               rd_v;
  logic               prod_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [SAMPLE_W-1:0]      res_sample;
  logic                     emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lpc_order        <= ORDER_RST;
      coef_precision   <= PREC_RST;
      prediction_shift <= SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LPC_ORDER:        lpc_order        <= cfg_data[ORDER_W-1:0];
        REG_COEF_PRECISION:   coef_precision   <= cfg_data[PREC_W-1:0];
        REG_PREDICTION_SHIFT: prediction_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clamp = lpc_order;
    if (lpc_order == '0) clamp = ORDER_W'(1);
    if (lpc_order > ORDER_W'(MAX_ORDER)) clamp = ORDER_W'(MAX_ORDER);
    eff_order = clamp[CW-1:0];
  end

  // sign-extend the raw coefficient at the configured precision
  always_comb begin
    prec = (coef_precision == '0) ? PREC_W'(1) : coef_precision;
    for (int i = 0; i < COEF_W; i++) begin
      coef_ext[i] = (PREC_W'(i) < prec) ? val_q[i] : val_q[prec - PREC_W'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      val_q  <= in_value;
      last_q <= in_last;
    end
  end

  assign emit       = ctl.warm || ctl.res || ctl.err;
  assign coef_we    = ctl.coef_wr && (coef_count < eff_order);
  assign hist_we    = ctl.warm || ctl.res;
  assign hist_wdata = ctl.res ? res_sample : val_q;
  assign hist_raddr = wp - AW'(1) - tap[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_count <= '0;
      warm_count <= '0;
      tap        <= '0;
      wp         <= '0;
      rd_v       <= 1'b0;
      prod_v     <= 1'b0;
    end else begin
      rd_v   <= ctl.tap_rd;
      prod_v <= rd_v;
      if (ctl.mac_clr) begin
        tap <= '0;
      end else if (ctl.tap_rd) begin
        tap <= tap + CW'(1);
      end
      if (hist_we) begin
        wp <= wp + AW'(1);
      end
      if (emit && last_q) begin
        coef_count <= '0;
        warm_count <= '0;
      end else begin
        if (coef_we) coef_count <= coef_count + CW'(1);
        if (ctl.warm && (warm_count < eff_order)) warm_count <= warm_count + CW'(1);
      end
    end
  end

  lpc_rs_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER), .AW(AW)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_count[AW-1:0]),
    .wdata (coef_ext),
    .raddr (tap[AW-1:0]),
    .rdata (coef_rdata)
  );

  lpc_rs_ram #(.WIDTH(SAMPLE_W), .DEPTH(HDEPTH), .AW(AW)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    prod <= $signed(coef_rdata) * $signed(hist_rdata);
    if (ctl.mac_clr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign acc_sh     = acc >>> prediction_shift;
  assign res_sample = acc_sh[SAMPLE_W-1:0] + val_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= ctl.err ? '0 : (ctl.res ? res_sample : val_q);
      out_last   <= last_q;
      out_error  <= ctl.err;
    end
  end

  assign sts.out_busy  = out_valid && !out_ready;
  assign sts.short_cnt = (coef_count < eff_order) || (warm_count < eff_order);
  assign sts.tap_more  = (tap + CW'(1)) < eff_order;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst) emit |-> !out_valid)
    else $error("result written over a pending transfer");
  a_mac_drained: assert property (@(posedge clk) disable iff (rst)
      ctl.res |-> (!rd_v && !prod_v))
    else $error("result taken before the MAC pipeline drained");
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
      ctl.tap_rd |-> (tap < eff_order))
    else $error("tap read beyond the order");
`endif

endmodule

>>> design/lpc_sample_restoration_top.sv
// Top level of the LPC sample restoration block.
//
// Input stream: tuser carries the item kind (coefficient, warm-up sample,
// residual), tdata the 32-bit value, tlast the end-of-block mark.
// Output stream: tdata carries the restored or echoed sample, tlast the
// copied end mark, tuser the sequence error flag.
// Registers lpc_order, coef_precision and prediction_shift are written on
// the cfg port (index 0, 1, 2); the user must write them only while the
// block is idle; the block does not enforce this. One item is in work
// at a time, driven by a microcoded sequencer. A residual runs one
// multiply-accumulate per tap through the shared multiplier, fed by the
// coefficient and history RAM read ports, then drains the pipeline; an
// early residual, short of coefficients or warm-up samples, is an error.
// The result sits in an output register; if the receiver stalls, the
// sequencer holds before writing the next result and stops taking input.
// Reset clears the registers to order 1, precision 12, shift 0 and both
// counts to zero; RAM contents are not cleared.
module lpc_sample_restoration_top
  import lpc_rs_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // value[31:0]
  input  logic                  s_axis_tlast,
  input  logic [1:0]            s_axis_tuser,  // op[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // sample[31:0]
  output logic                  m_axis_tlast,
  output logic [0:0]            m_axis_tuser   // error[0]
);

  ctl_t ctl;
  sts_t sts;
  logic accept;

  assign s_axis_tready = ctl.in_rdy;
  assign accept        = s_axis_tvalid && ctl.in_rdy;

  lpc_rs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (op_t'(s_axis_tuser)),
    .sts      (sts),
    .ctl      (ctl)
  );

  lpc_rs_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (accept),
    .in_value   (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_error  (m_axis_tuser[0])
  );

endmodule

>>> sim/lpc_sample_restoration_top_test.sv
// Self-checking testbench for the LPC sample restoration top level.
module lpc_sample_restoration_top_test;
  import lpc_rs_pkg::*;

  localparam int ITEMS       = 1100;
  localparam int QUIET_ITEMS = 150;
  localparam int SETTLE      = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS    = 13;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
    logic        err;
  } sample_res_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic        last;
    logic        typed;
    sample_res_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;  // value[31:0]
  logic                  s_axis_tlast = 1'b0;
  logic [1:0]            s_axis_tuser = '0;  // op[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;       // sample[31:0]
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;       // error[0]

  logic [5:0]  cur_order = ORDER_RST;
  logic [3:0]  cur_prec = PREC_RST;
  logic [3:0]  cur_shift = SHIFT_RST;
  int          coef_mem [MAX_ORDER_DEF];
  logic [31:0] history [MAX_ORDER_DEF];
  int          coef_count = 0;
  int          warm_count = 0;

  sample_res_t expected_samples [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_stall = 0;

  lpc_sample_restoration_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic dir_row_t mk_row(op_t op, logic [31:0] value, logic last, logic typed,
                                      logic [31:0] s, logic l, logic e);
    dir_row_t row;
    row.op = op;
    row.value = value;
    row.last = last;
    row.typed = typed;
    row.want.sample = s;
    row.want.last = l;
    row.want.err = e;
    return row;
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'(int'($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic shift_history(input logic [31:0] s);
    int j;
    for (j = MAX_ORDER_DEF - 1; j > 0; j--) history[j] = history[j-1];
    history[0] = s;
  endtask

  task automatic predict_sample(input op_t op, input logic [31:0] value, input logic last,
                                output bit produces, output sample_res_t res);
    int          taps, p, h, j;
    longint      acc;
    logic [31:0] raw, mask;
    taps = (cur_order == 0) ? 1 :
           (cur_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(cur_order);
    produces = 1'b0;
    res = '0;
    res.last = last;
    case (op)
      OP_COEF: begin
        p = (cur_prec == 0) ? 1 : int'(cur_prec);
        mask = (32'd1 << p) - 32'd1;
        raw = value & mask;
        if (raw[p-1]) raw = raw | ~mask;
        if (coef_count < taps) begin
          coef_mem[coef_count] = int'(raw);
          coef_count++;
        end
      end
      OP_WARM: begin
        shift_history(value);
        if (warm_count < taps) warm_count++;
        res.sample = value;
        produces = 1'b1;
      end
      OP_RES: begin
        produces = 1'b1;
        if (coef_count < taps || warm_count < taps) begin
          res.err = 1'b1;
        end else begin
          acc = 0;
          for (j = 0; j < taps; j++) begin
            h = history[j];
            acc += longint'(coef_mem[j]) * longint'(h);
          end
          acc = acc >>> cur_shift;
          res.sample = acc[31:0] + value;
          shift_history(res.sample);
        end
      end
      default: ;
    endcase
    if (produces && last) begin
      coef_count = 0;
      warm_count = 0;
    end
  endtask

  task automatic send_item(input op_t op, input logic [31:0] value, input logic last,
                           input logic typed, input sample_res_t want);
    int          gap;
    bit          produces;
    sample_res_t res;
    if (items_sent >= ITEMS - QUIET_ITEMS) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= value;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_sample(op, value, last, produces, res);
    if (produces) expected_samples.push_back(typed ? want : res);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [5:0] ord, input logic [3:0] prec,
                              input logic [3:0] sh);
    logic [1:0] pad;
    pad = 2'($urandom_range(0, 3));
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LPC_ORDER;
    cfg_data <= ord;
    @(negedge clk);
    cfg_index <= REG_COEF_PRECISION;
    cfg_data <= {pad, prec};
    pad = 2'($urandom_range(0, 3));
    @(negedge clk);
    cfg_index <= REG_PREDICTION_SHIFT;
    cfg_data <= {pad, sh};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_order = ord;
    cur_prec = prec;
    cur_shift = sh;
  endtask

  task automatic send_subframe(input int taps);
    int kind, n_coef, n_warm, n_res, k;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(op_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 3) == 0, 1'b0, '0);
      return;
    end
    n_coef = taps;
    n_warm = taps;
    if (kind == 1) begin
      n_coef = taps + int'($urandom_range(0, 2)) - 1;
      n_warm = taps + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) send_item(OP_RES, random_sample(), 1'b0, 1'b0, '0);
    end
    for (k = 0; k < n_coef; k++)
      send_item(OP_COEF, $urandom, kind == 1 && $urandom_range(0, 3) == 0, 1'b0, '0);
    for (k = 0; k < n_warm; k++)
      send_item(OP_WARM, random_sample(), 1'b0, 1'b0, '0);
    if (kind == 1 && $urandom_range(0, 1))
      send_item(OP_NONE, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
    n_res = $urandom_range(1, 6);
    for (k = 0; k < n_res; k++)
      send_item(OP_RES, random_sample(), k == n_res - 1, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_stall <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_output
    sample_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        if (mismatch_count < 10)
          $display("cycle %0d: unexpected output transfer, sample %h last %0b error %0b",
                   cycle_count, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata !== want.sample || m_axis_tlast !== want.last ||
            m_axis_tuser[0] !== want.err) begin
          if (mismatch_count < 10)
            $display("cycle %0d: sample %h/%h last %0b/%0b error %0b/%0b (expected/actual)",
                     cycle_count, want.sample, m_axis_tdata, want.last, m_axis_tlast,
                     want.err, m_axis_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lpc_sample_restoration_top_test: errors");
    $finish;
  end

  initial begin
    int         phase, taps, i, r;
    logic [5:0] ord;
    logic [3:0] prec, sh;

    for (i = 0; i < MAX_ORDER_DEF; i++) begin
      coef_mem[i] = 0;
      history[i] = '0;
    end

    // order 1, precision 12, shift 0 from reset
    dir_rows[0]  = mk_row(OP_RES,  32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b1);
    dir_rows[1]  = mk_row(OP_WARM, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    dir_rows[2]  = mk_row(OP_RES,  32'h0000_0007, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
    dir_rows[3]  = mk_row(OP_COEF, 32'hFFFF_F800, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[4]  = mk_row(OP_COEF, 32'h0000_0123, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[5]  = mk_row(OP_RES,  32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[6]  = mk_row(OP_NONE, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[7]  = mk_row(OP_WARM, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    dir_rows[8]  = mk_row(OP_RES,  32'h8000_0000, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[9]  = mk_row(OP_COEF, 32'h0000_07FF, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    dir_rows[10] = mk_row(OP_RES,  32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
    dir_rows[11] = mk_row(OP_WARM, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
    dir_rows[12] = mk_row(OP_RES,  32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].want);
    settle();

    phase = 0;
    while (items_sent < ITEMS) begin
      case (phase)
        0: begin ord = 6'd32; prec = 4'd15; sh = 4'd15; end
        1: begin ord = 6'd1;  prec = 4'd1;  sh = 4'd0;  end
        2: begin ord = 6'd0;  prec = 4'd0;  sh = 4'd15; end
        3: begin ord = 6'd63; prec = 4'd15; sh = 4'd0;  end
        default: begin
          r = $urandom_range(0, 15);
          ord = (r < 11) ? 6'($urandom_range(1, 4)) :
                (r < 14) ? 6'($urandom_range(5, 32)) :
                (r == 14) ? 6'd0 : 6'($urandom_range(33, 63));
          prec = 4'($urandom_range(0, 15));
          sh = 4'($urandom_range(0, 15));
        end
      endcase
      write_config(ord, prec, sh);
      if (items_sent < ITEMS - QUIET_ITEMS) begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 10 : 30);
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 10 : 30);
      end
      taps = (ord == 0) ? 1 : (ord > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(ord);
      repeat ((taps > 8) ? 1 : $urandom_range(1, 4)) send_subframe(taps);
      settle();
      phase++;
    end

    if (mismatch_count == 0)
      $display("lpc_sample_restoration_top_test: clean");
    else
      $display("lpc_sample_restoration_top_test: errors");
    $finish;
  end

endmodule
